>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/sfba_pkg.sv
// shared types, codes and constants of the segregated fit allocator
`timescale 1ns / 1ps

package sfba_pkg;

    localparam int BLOCKS_PER_CLASS_DEF = 32;
    localparam int NUM_CLASSES_DEF      = 3;
    localparam int SIZE_BITS_DEF        = 13;

    localparam int REQ_W       = 13;
    localparam int LIDX_W      = 5;
    localparam int CLS_IN_W    = 2;
    localparam int OUT_BYTES_W = 13;
    localparam int TOT_W       = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_W-1:0] SMALL_LIMIT_RST  = 13'd256;
    localparam logic [CFG_W-1:0] MEDIUM_LIMIT_RST = 13'd1024;
    localparam logic [CFG_W-1:0] LARGE_LIMIT_RST  = 13'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE    = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [1:0] ST_GRANTED   = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_LOADED    = 2'd3;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                op;
        logic [CLS_IN_W-1:0] cls;
        logic [1:0]          mode;
        logic                commit;
    } t_cmd;

    // control part of the search token that walks the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } t_tok;

endpackage

>>> hdl/sfba_cell.sv
// one cell of the row: entries of one table position in every class
`timescale 1ns / 1ps

module sfba_cell #(
    parameter int BLOCKS_PER_CLASS = sfba_pkg::BLOCKS_PER_CLASS_DEF,
    parameter int NUM_CLASSES      = sfba_pkg::NUM_CLASSES_DEF,
    parameter int SIZE_BITS        = sfba_pkg::SIZE_BITS_DEF,
    parameter int CELL_IDX         = 0,
    localparam int IDX_W = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1,
    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    localparam int CMP_W = (SIZE_BITS > sfba_pkg::REQ_W) ? SIZE_BITS : sfba_pkg::REQ_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfba_pkg::t_cmd              i_cmd,
    input  logic [sfba_pkg::REQ_W-1:0]  i_req,
    input  logic [SIZE_BITS-1:0]        i_bytes,
    input  logic [sfba_pkg::LIDX_W-1:0] i_load_idx,
    input  logic [IDX_W-1:0]            i_commit_pick,
    input  logic [SIZE_BITS-1:0]        i_commit_left,
    input  sfba_pkg::t_tok              i_tok,
    input  logic [IDX_W-1:0]            i_tok_pick,
    input  logic [SIZE_BITS-1:0]        i_tok_left,
    output sfba_pkg::t_tok              o_tok,
    output logic [IDX_W-1:0]            o_tok_pick,
    output logic [SIZE_BITS-1:0]        o_tok_left
);

    logic [SIZE_BITS-1:0]   r_bytes [NUM_CLASSES];
    logic [SIZE_BITS-1:0]   r_waste [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_loaded;
    logic [NUM_CLASSES-1:0] r_used;
    sfba_pkg::t_tok         r_tok;
    logic [IDX_W-1:0]       r_tok_pick;
    logic [SIZE_BITS-1:0]   r_tok_left;

    sfba_pkg::t_tok         n_tok;
    logic [IDX_W-1:0]       n_tok_pick;
    logic [SIZE_BITS-1:0]   n_tok_left;

    logic [CLS_W-1:0]       w_cls;
    logic [SIZE_BITS-1:0]   w_sel_bytes;
    logic [SIZE_BITS-1:0]   w_left;
    logic                   w_here_load;
    logic                   w_load_we;
    logic                   w_fits;
    logic                   w_take;
    logic                   w_commit_here;

    assign w_cls         = i_cmd.cls[CLS_W-1:0];
    assign w_sel_bytes   = r_bytes[w_cls];
    assign w_here_load   = (32'(i_load_idx) == CELL_IDX);
    assign w_load_we     = i_tok.valid && (i_cmd.op == sfba_pkg::OP_LOAD) && w_here_load;
    assign w_left        = SIZE_BITS'(CMP_W'(w_sel_bytes) - CMP_W'(i_req));
    assign w_fits        = r_loaded[w_cls] && !r_used[w_cls]
                           && (CMP_W'(w_sel_bytes) >= CMP_W'(i_req));
    assign w_take        = w_fits && (!i_tok.found
                           || ((i_cmd.mode == sfba_pkg::MODE_BEST) && (w_left < i_tok_left))
                           || ((i_cmd.mode == sfba_pkg::MODE_WORST) && (w_left > i_tok_left)));
    assign w_commit_here = i_cmd.commit && (i_commit_pick == IDX_W'(CELL_IDX));

    always_comb begin
        n_tok      = i_tok;
        n_tok_pick = i_tok_pick;
        n_tok_left = i_tok_left;
        if (i_cmd.op == sfba_pkg::OP_LOAD) begin
            // hand back the waste this entry held so the total can drop it
            if (w_here_load && r_used[w_cls]) begin
                n_tok_left = r_waste[w_cls];
            end
        end else if (w_take) begin
            n_tok.found = 1'b1;
            n_tok_pick  = IDX_W'(CELL_IDX);
            n_tok_left  = w_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_loaded <= '0;
            r_used   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_load_we) begin
                r_loaded[w_cls] <= 1'b1;
                r_used[w_cls]   <= 1'b0;
            end
            if (w_commit_here) begin
                r_used[w_cls] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_pick <= n_tok_pick;
        r_tok_left <= n_tok_left;
        if (w_load_we) begin
            r_bytes[w_cls] <= i_bytes;
            r_waste[w_cls] <= '0;
        end
        if (w_commit_here) begin
            r_waste[w_cls] <= i_commit_left;
        end
    end

    assign o_tok      = r_tok;
    assign o_tok_pick = r_tok_pick;
    assign o_tok_left = r_tok_left;

endmodule

>>> hdl/segregated_fit_block_allocator.sv
// top level: request decode, cell row, waste totals and result register
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser op, tdata class/index/bytes/size
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser status, tdata class..waste
// cfg       in   i_cfg_we                       i_cfg_index, i_cfg_data
//
// a load or allocate walks a token through the row of BLOCKS_PER_CLASS cells,
// one cell per cycle; rejected or out of range items skip the row
// one item at a time; the next request is taken once the result is registered
// a stalled result holds in the output register; reset is synchronous, active low
`timescale 1ns / 1ps

module segregated_fit_block_allocator #(
    parameter int BLOCKS_PER_CLASS = sfba_pkg::BLOCKS_PER_CLASS_DEF,
    parameter int NUM_CLASSES      = sfba_pkg::NUM_CLASSES_DEF,
    parameter int SIZE_BITS        = sfba_pkg::SIZE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfba_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_class, load_index, block_bytes, request_size, zero pad
    input  logic [sfba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chosen_class, chosen_index, granted_bytes, leftover, class_waste, zero pad
    output logic [sfba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                        m_axis_tuser
);

    localparam int IDX_W = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CMP_W = (SIZE_BITS > sfba_pkg::REQ_W) ? SIZE_BITS : sfba_pkg::REQ_W;
    localparam int PAD_W = sfba_pkg::OUT_TDATA_W - sfba_pkg::TOT_W
                           - 2 * sfba_pkg::OUT_BYTES_W - sfba_pkg::LIDX_W
                           - sfba_pkg::CLS_IN_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_fit_mode;
    logic [sfba_pkg::CFG_W-1:0]      r_small;
    logic [sfba_pkg::CFG_W-1:0]      r_medium;
    logic [sfba_pkg::CFG_W-1:0]      r_large;
    logic                            r_op;
    logic [sfba_pkg::CLS_IN_W-1:0]   r_cls;
    logic [sfba_pkg::LIDX_W-1:0]     r_idx;
    logic [sfba_pkg::REQ_W-1:0]      r_req;
    logic [SIZE_BITS-1:0]            r_bytes;
    logic                            r_imm;
    logic [1:0]                      r_imm_status;
    logic                            r_launch;
    logic                            r_commit;
    logic                            r_fin_found;
    logic [IDX_W-1:0]                r_fin_pick;
    logic [SIZE_BITS-1:0]            r_fin_left;
    logic [sfba_pkg::TOT_W-1:0]      r_total [NUM_CLASSES];
    logic                            r_m_valid;
    logic [sfba_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic [1:0]                      r_m_tuser;

    logic                            w_accept;
    logic                            w_op;
    logic [sfba_pkg::CLS_IN_W-1:0]   w_lcls;
    logic [sfba_pkg::LIDX_W-1:0]     w_lidx;
    logic [sfba_pkg::REQ_W-1:0]      w_lbytes;
    logic [sfba_pkg::REQ_W-1:0]      w_req;
    logic [sfba_pkg::CLS_IN_W-1:0]   w_rcls;
    logic                            w_too_large;
    logic                            w_load_bad;
    logic                            w_go_scan;
    logic                            w_out_free;
    logic [sfba_pkg::TOT_W-1:0]      w_sel_total;
    logic [sfba_pkg::TOT_W-1:0]      n_total;
    logic [1:0]                      n_status;
    logic [sfba_pkg::CLS_IN_W-1:0]   n_cls;
    logic [sfba_pkg::LIDX_W-1:0]     n_idx;
    logic [sfba_pkg::OUT_BYTES_W-1:0] n_granted;
    logic [sfba_pkg::OUT_BYTES_W-1:0] n_leftover;
    logic [sfba_pkg::TOT_W-1:0]      n_waste;

    sfba_pkg::t_cmd                  w_cmd;
    sfba_pkg::t_tok                  w_tok  [BLOCKS_PER_CLASS+1];
    logic [IDX_W-1:0]                w_pick [BLOCKS_PER_CLASS+1];
    logic [SIZE_BITS-1:0]            w_left [BLOCKS_PER_CLASS+1];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_op     = s_axis_tuser[0];
    assign w_lcls   = s_axis_tdata[1:0];
    assign w_lidx   = s_axis_tdata[6:2];
    assign w_lbytes = s_axis_tdata[19:7];
    assign w_req    = s_axis_tdata[32:20];

    // limits are tested in order whatever their relative values
    always_comb begin
        w_too_large = 1'b0;
        if (w_req < r_small) begin
            w_rcls = 2'd0;
        end else if (w_req < r_medium) begin
            w_rcls = 2'd1;
        end else if (w_req < r_large) begin
            w_rcls = 2'd2;
        end else begin
            w_rcls      = 2'd0;
            w_too_large = 1'b1;
        end
    end

    assign w_load_bad = (32'(w_lcls) >= NUM_CLASSES) || (32'(w_lidx) >= BLOCKS_PER_CLASS);

    // request that needs a walk through the row
    assign w_go_scan = (w_op == sfba_pkg::OP_LOAD) ? !w_load_bad
                       : !(w_too_large || (32'(w_rcls) >= NUM_CLASSES));

    // cell row
    assign w_cmd.op     = r_op;
    assign w_cmd.cls    = r_cls;
    assign w_cmd.mode   = r_fit_mode;
    assign w_cmd.commit = r_commit;

    assign w_tok[0].valid = r_launch;
    assign w_tok[0].found = 1'b0;
    assign w_pick[0]      = '0;
    assign w_left[0]      = '0;

    for (genvar g = 0; g < BLOCKS_PER_CLASS; g++) begin : g_cell
        sfba_cell #(
            .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
            .NUM_CLASSES      (NUM_CLASSES),
            .SIZE_BITS        (SIZE_BITS),
            .CELL_IDX         (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_req         (r_req),
            .i_bytes       (r_bytes),
            .i_load_idx    (r_idx),
            .i_commit_pick (r_fin_pick),
            .i_commit_left (r_fin_left),
            .i_tok         (w_tok[g]),
            .i_tok_pick    (w_pick[g]),
            .i_tok_left    (w_left[g]),
            .o_tok         (w_tok[g+1]),
            .o_tok_pick    (w_pick[g+1]),
            .o_tok_left    (w_left[g+1])
        );
    end

    // result of the finished item
    assign w_out_free  = !r_m_valid || m_axis_tready;
    assign w_sel_total = r_total[r_cls[CLS_W-1:0]];

    always_comb begin
        n_total    = w_sel_total;
        n_status   = r_imm_status;
        n_cls      = r_cls;
        n_idx      = '0;
        n_granted  = '0;
        n_leftover = '0;
        n_waste    = '0;
        if (!r_imm) begin
            if (r_op == sfba_pkg::OP_LOAD) begin
                n_total  = w_sel_total - sfba_pkg::TOT_W'(r_fin_left);
                n_status = sfba_pkg::ST_LOADED;
                n_idx    = r_idx;
                n_waste  = n_total;
            end else if (r_fin_found) begin
                n_total    = w_sel_total + sfba_pkg::TOT_W'(r_fin_left);
                n_status   = sfba_pkg::ST_GRANTED;
                n_idx      = sfba_pkg::LIDX_W'(r_fin_pick);
                n_granted  = sfba_pkg::OUT_BYTES_W'(CMP_W'(r_req) + CMP_W'(r_fin_left));
                n_leftover = sfba_pkg::OUT_BYTES_W'(r_fin_left);
                n_waste    = n_total;
            end else begin
                n_status = sfba_pkg::ST_NO_FIT;
                n_waste  = w_sel_total;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= '0;
            r_small    <= sfba_pkg::SMALL_LIMIT_RST;
            r_medium   <= sfba_pkg::MEDIUM_LIMIT_RST;
            r_large    <= sfba_pkg::LARGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfba_pkg::CFG_FIT_MODE: r_fit_mode <= i_cfg_data[1:0];
                sfba_pkg::CFG_SMALL:    r_small    <= i_cfg_data;
                sfba_pkg::CFG_MEDIUM:   r_medium   <= i_cfg_data;
                sfba_pkg::CFG_LARGE:    r_large    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_commit  <= 1'b0;
            r_m_valid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_total[k] <= '0;
            end
        end else begin
            r_launch <= (r_state == S_IDLE) && w_accept && w_go_scan;
            r_commit <= (r_state == S_FIN) && w_out_free && !r_imm
                        && (r_op == sfba_pkg::OP_ALLOC) && r_fin_found;
            if ((r_state == S_FIN) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_go_scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[BLOCKS_PER_CLASS].valid) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (!r_imm) begin
                            r_total[r_cls[CLS_W-1:0]] <= n_total;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= w_op;
            r_idx   <= w_lidx;
            r_req   <= w_req;
            r_bytes <= SIZE_BITS'(w_lbytes);
            if (w_op == sfba_pkg::OP_LOAD) begin
                r_cls        <= w_load_bad ? '0 : w_lcls;
                r_imm        <= w_load_bad;
                r_imm_status <= sfba_pkg::ST_LOADED;
            end else if (w_too_large) begin
                r_cls        <= '0;
                r_imm        <= 1'b1;
                r_imm_status <= sfba_pkg::ST_TOO_LARGE;
            end else begin
                r_cls        <= w_rcls;
                r_imm        <= (32'(w_rcls) >= NUM_CLASSES);
                r_imm_status <= sfba_pkg::ST_NO_FIT;
            end
        end
        if ((r_state == S_SCAN) && w_tok[BLOCKS_PER_CLASS].valid) begin
            r_fin_found <= w_tok[BLOCKS_PER_CLASS].found;
            r_fin_pick  <= w_pick[BLOCKS_PER_CLASS];
            r_fin_left  <= w_left[BLOCKS_PER_CLASS];
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_m_tdata <= {{PAD_W{1'b0}}, n_waste, n_leftover, n_granted, n_idx, n_cls};
            r_m_tuser <= n_status;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

>>> hdl/sfba_checker.sv
// port-level checks of the allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfba_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sfba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);

    // a stalled result keeps its contents
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one request in flight at a time
    `ASSERT_NEXT(a_one_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // rejected request carries no class, entry or totals
    `ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == sfba_pkg::ST_TOO_LARGE), m_axis_tdata == '0)

    // a grant never leaves more than the block holds
    `ASSERT_IMPLY(a_grant_left, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == sfba_pkg::ST_GRANTED), m_axis_tdata[32:20] <= m_axis_tdata[19:7])

endmodule

bind segregated_fit_block_allocator sfba_checker u_sfba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
